// ===== rtl/iei_pkg.sv =====
// Shared types, codes and constants for the isosurface edge interpolator.
package iei_pkg;

	// Field widths fixed by the interface.
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = 13;
	localparam int Q_SHIFT   = 16;
	localparam int REG_IDX_W = 4;

	// Divider geometry: magnitude of (iso - s0) * 2^16 and of (s1 - s0).
	localparam int DIFF_W    = VALUE_W + 1;
	localparam int NUM_MAG_W = DIFF_W + Q_SHIFT;
	localparam int DEN_MAG_W = DIFF_W;
	localparam int DIV_STEPS = VALUE_W - 1;
	localparam int PROD_W    = VALUE_W + DIFF_W;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [IDX_W-1:0] NUM_POINTS_RESET = IDX_W'(4096);

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ISO_LEVEL  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_NUM_POINTS = REG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_LOAD_POINT = 2'd0,
		OP_LOAD_CELL  = 2'd1,
		OP_INTERP     = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_SNAP = 2'd1,
		STAT_AVG  = 2'd2,
		STAT_BAD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ1,
		S_READ2,
		S_DIV_GO,
		S_DIV_WAIT,
		S_MUL,
		S_ADD,
		S_DONE
	} iei_state_t;

	typedef struct packed {
		op_t                       operation;
		logic [IDX_W-1:0]          first_index;
		logic [IDX_W-1:0]          second_index;
		logic signed [VALUE_W-1:0] level_in;
		logic signed [VALUE_W-1:0] data_in;
	} iei_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		status_t                   status;
	} iei_out_t;

	// One store entry: iso-field level and data value.
	typedef struct packed {
		logic signed [VALUE_W-1:0] level;
		logic signed [VALUE_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [NUM_MAG_W-1:0] num_mag;
		logic [DEN_MAG_W-1:0] den_mag;
	} div_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [VALUE_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/iei_store.sv =====
// Single-port-write, single-port-read entry store with registered read data.
module iei_store #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  iei_pkg::entry_t wr_entry,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output iei_pkg::entry_t rd_entry
);
	import iei_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	// Read port; the read data is registered from the address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

// ===== rtl/iei_divider.sv =====
// Radix-2 restoring divider for the saturated Q16.16 interpolation ratio.
module iei_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  iei_pkg::div_req_t req,
	output iei_pkg::div_rsp_t rsp
);
	import iei_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam int REM_W = DEN_MAG_W + 1;
	localparam int LO_W  = DIV_STEPS;

	logic [REM_W-1:0]     rem_q;
	logic [LO_W-1:0]      lo_q;
	logic [LO_W-1:0]      quo_q;
	logic [DEN_MAG_W-1:0] den_q;
	logic                 neg_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [REM_W-1:0]     rem_sh;
	logic                 take;
	logic [REM_W-1:0]     rem_hi;
	logic [VALUE_W-1:0]   quo_pos;

	// One quotient bit per cycle: shift in the next numerator bit and try a subtract.
	assign rem_sh = {rem_q[REM_W-2:0], lo_q[LO_W-1]};
	assign take   = rem_sh >= REM_W'(den_q);

	// Quotient of 2^31 or more saturates; detected once from the top numerator bits.
	assign rem_hi = REM_W'(req.num_mag[NUM_MAG_W-1:LO_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_hi;
			lo_q  <= req.num_mag[LO_W-1:0];
			den_q <= req.den_mag;
			neg_q <= req.neg;
			ovf_q <= rem_hi >= REM_W'(req.den_mag);
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - REM_W'(den_q)) : rem_sh;
			lo_q  <= {lo_q[LO_W-2:0], 1'b0};
			quo_q <= {quo_q[LO_W-2:0], take};
		end
	end

	// Apply the sign, truncating toward zero, and saturate.
	assign quo_pos = {1'b0, quo_q};

	always_comb begin
		rsp.done = done_q;
		if (ovf_q) begin
			rsp.quot = neg_q ? VAL_MIN : VAL_MAX;
		end else if (neg_q) begin
			rsp.quot = VALUE_W'(0) - quo_pos;
		end else begin
			rsp.quot = quo_pos;
		end
	end

endmodule

// ===== rtl/iso_edge_interpolator_core.sv =====
// Top level of the isosurface edge interpolator: stores, sequencer and datapath.
//
// Channel   Direction  Handshake                Beat
// in        input      in_valid / in_ready      iei_in_t: operation, indexes, level, data
// out       output     out_valid / out_ready    iei_out_t: result_value, status
// cfg       input      cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// From acceptance, a load or a rejected beat goes straight to the done state; a snapped edge or
// a bad second index passes one store read first, and equal levels both reads. A full interpolation
// runs two store reads, a divider start, 31 quotient steps, the divider's done flag, multiply, add, load.
// in_ready is high only in the idle state, so a new beat is taken only after the last one is loaded out.
// Reset clears the sequencer, the output valid flag and the configuration registers;
// the stores are not cleared. A stalled output holds the sequencer in its done state.
module iso_edge_interpolator_core #(
	parameter int POINT_DEPTH = 4096,
	parameter int CELL_DEPTH  = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  iei_pkg::iei_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output iei_pkg::iei_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iei_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [iei_pkg::VALUE_W-1:0]          cfg_data
);
	import iei_pkg::*;

	localparam int PA_W = $clog2(POINT_DEPTH);
	localparam int CA_W = $clog2(CELL_DEPTH);
	localparam logic [31:0] PT_LIM = 32'(POINT_DEPTH);
	localparam logic [31:0] CL_LIM = 32'(CELL_DEPTH);

	typedef struct packed {
		logic             ok;
		logic             is_point;
		logic [IDX_W-1:0] idx;
	} endpoint_t;

	// Maps a combined index to a store and an entry, with its range check.
	function automatic endpoint_t resolve(input logic [IDX_W-1:0] idx,
		input logic [IDX_W-1:0] np);
		endpoint_t ep;
		logic [IDX_W-1:0] cidx;
		cidx = idx - np;
		ep.is_point = idx < np;
		ep.idx = ep.is_point ? idx : cidx;
		ep.ok = ep.is_point ? (32'(idx) < PT_LIM) : (32'(cidx) < CL_LIM);
		return ep;
	endfunction

	iei_state_t state_q, state_d;

	logic signed [VALUE_W-1:0] iso_q;
	logic [IDX_W-1:0]          np_q;

	logic                      sel0_q, sel1_q, snap_q, ok1_q;
	logic [IDX_W-1:0]          idx1_q;
	logic signed [VALUE_W-1:0] s0_q, v0_q;
	logic signed [DIFF_W-1:0]  num_q, den_q, dv_q;
	logic signed [VALUE_W-1:0] s_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [VALUE_W-1:0] res_q;
	status_t                   stat_q;
	logic                      out_valid_q;
	iei_out_t                  out_q;

	logic      in_fire, out_load;
	endpoint_t ep0, ep1;
	logic      pt_wr_en, cl_wr_en, pt_rd_en, cl_rd_en;
	logic [IDX_W-1:0] rd_idx;
	entry_t    wr_entry, pt_rd, cl_rd, rd_entry;
	logic      lvl_eq;
	logic signed [DIFF_W-1:0]  pair_sum;
	logic signed [PROD_W:0]    acc;
	logic [DIFF_W-1:0]         num_abs, den_abs;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	// Handshakes.
	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign ep0 = resolve(in_data.first_index, np_q);
	assign ep1 = resolve(in_data.second_index, np_q);

	// Store writes come straight from an accepted load beat.
	assign wr_entry = '{level: in_data.level_in, data: in_data.data_in};
	assign pt_wr_en = in_fire && (in_data.operation == OP_LOAD_POINT)
		&& (32'(in_data.first_index) < PT_LIM);
	assign cl_wr_en = in_fire && (in_data.operation == OP_LOAD_CELL)
		&& (32'(in_data.first_index) < CL_LIM);

	// First endpoint is read on acceptance, the second one in the S_READ1 state that follows.
	always_comb begin
		pt_rd_en = 1'b0;
		cl_rd_en = 1'b0;
		rd_idx   = ep0.idx;
		if (state_q == S_IDLE) begin
			if (in_fire && (in_data.operation == OP_INTERP) && ep0.ok) begin
				pt_rd_en = ep0.is_point;
				cl_rd_en = !ep0.is_point;
			end
		end else if (state_q == S_READ1) begin
			rd_idx = idx1_q;
			if (ok1_q && !snap_q) begin
				pt_rd_en = sel1_q;
				cl_rd_en = !sel1_q;
			end
		end
	end

	iei_store #(.DEPTH(POINT_DEPTH)) u_point_store (
		.clk      (clk),
		.wr_en    (pt_wr_en),
		.wr_addr  (PA_W'(in_data.first_index)),
		.wr_entry (wr_entry),
		.rd_en    (pt_rd_en),
		.rd_addr  (PA_W'(rd_idx)),
		.rd_entry (pt_rd)
	);

	iei_store #(.DEPTH(CELL_DEPTH)) u_cell_store (
		.clk      (clk),
		.wr_en    (cl_wr_en),
		.wr_addr  (CA_W'(in_data.first_index)),
		.wr_entry (wr_entry),
		.rd_en    (cl_rd_en),
		.rd_addr  (CA_W'(rd_idx)),
		.rd_entry (cl_rd)
	);

	// Read data of whichever store the current endpoint lives in.
	always_comb begin
		if (state_q == S_READ1) begin
			rd_entry = sel0_q ? pt_rd : cl_rd;
		end else begin
			rd_entry = sel1_q ? pt_rd : cl_rd;
		end
	end

	assign lvl_eq   = rd_entry.level == s0_q;
	assign pair_sum = DIFF_W'(v0_q) + DIFF_W'(rd_entry.data);

	// Divider operands: magnitudes of (iso - s0) * 2^16 and (s1 - s0).
	assign num_abs = num_q[DIFF_W-1] ? (DIFF_W'(0) - num_q) : num_q;
	assign den_abs = den_q[DIFF_W-1] ? (DIFF_W'(0) - den_q) : den_q;

	always_comb begin
		div_req.start   = state_q == S_DIV_GO;
		div_req.neg     = num_q[DIFF_W-1] ^ den_q[DIFF_W-1];
		div_req.num_mag = {num_abs, {Q_SHIFT{1'b0}}};
		div_req.den_mag = den_abs;
	end

	iei_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Final sum: v0 plus the floored, rescaled product.
	assign acc = (PROD_W + 1)'(v0_q) + (PROD_W + 1)'(prod_q >>> Q_SHIFT);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if ((in_data.operation == OP_INTERP) && ep0.ok) begin
						state_d = S_READ1;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_READ1: begin
				state_d = (snap_q || !ok1_q) ? S_DONE : S_READ2;
			end
			S_READ2: begin
				state_d = lvl_eq ? S_DONE : S_DIV_GO;
			end
			S_DIV_GO: begin
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Datapath registers, loaded step by step as the item moves through the sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					sel0_q <= ep0.is_point;
					sel1_q <= ep1.is_point;
					idx1_q <= ep1.idx;
					ok1_q  <= ep1.ok;
					snap_q <= in_data.second_index == in_data.first_index;
					res_q  <= '0;
					case (in_data.operation)
						OP_LOAD_POINT: stat_q <= pt_wr_en ? STAT_OK : STAT_BAD;
						OP_LOAD_CELL:  stat_q <= cl_wr_en ? STAT_OK : STAT_BAD;
						default:       stat_q <= STAT_BAD;
					endcase
				end
			end
			S_READ1: begin
				s0_q <= rd_entry.level;
				v0_q <= rd_entry.data;
				if (snap_q) begin
					res_q  <= rd_entry.data;
					stat_q <= STAT_SNAP;
				end
			end
			S_READ2: begin
				num_q <= DIFF_W'(iso_q) - DIFF_W'(s0_q);
				den_q <= DIFF_W'(rd_entry.level) - DIFF_W'(s0_q);
				dv_q  <= DIFF_W'(rd_entry.data) - DIFF_W'(v0_q);
				if (lvl_eq) begin
					res_q  <= pair_sum[DIFF_W-1:1];
					stat_q <= STAT_AVG;
				end else begin
					stat_q <= STAT_OK;
				end
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					s_q <= div_rsp.quot;
				end
			end
			S_MUL: begin
				prod_q <= s_q * dv_q;
			end
			S_ADD: begin
				if (acc > (PROD_W + 1)'(VAL_MAX)) begin
					res_q <= VAL_MAX;
				end else if (acc < (PROD_W + 1)'(VAL_MIN)) begin
					res_q <= VAL_MIN;
				end else begin
					res_q <= acc[VALUE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds one finished beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{result_value: res_q, status: stat_q};
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			np_q  <= NUM_POINTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ISO_LEVEL:  iso_q <= cfg_data;
				REG_NUM_POINTS: np_q  <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== dv/iso_edge_interpolator_core_test.sv =====
// Self-checking testbench for the isosurface edge interpolator core.
module iso_edge_interpolator_core_test;

	import iei_pkg::*;

	localparam int POINT_DEPTH  = 4096;
	localparam int CELL_DEPTH   = 4096;
	localparam int PHASE_ITEMS  = 125;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD    = 300;
	localparam int IDX_MAX      = (1 << IDX_W) - 1;

	// The operation code the package leaves without a member.
	localparam op_t OP_UNUSED = op_t'(2'd3);
	// Register indexes from here up are not mapped.
	localparam int REG_UNMAPPED_LO = 2;

	localparam logic signed [VALUE_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [VALUE_W-1:0] Q_M_ONE = -32'sh0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	iei_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	iei_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0] cfg_data = '0;

	iso_edge_interpolator_core #(
		.POINT_DEPTH(POINT_DEPTH),
		.CELL_DEPTH (CELL_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the block: configuration and the two stores, kept as four arrays.
	logic signed [VALUE_W-1:0] iso_setting = '0;
	logic [IDX_W-1:0] point_count = NUM_POINTS_RESET;
	logic signed [VALUE_W-1:0] pt_level [POINT_DEPTH];
	logic signed [VALUE_W-1:0] pt_data [POINT_DEPTH];
	logic signed [VALUE_W-1:0] cl_level [CELL_DEPTH];
	logic signed [VALUE_W-1:0] cl_data [CELL_DEPTH];

	// Which entries the stimulus has loaded so far.
	bit pt_loaded [POINT_DEPTH];
	bit cl_loaded [CELL_DEPTH];
	int pt_loaded_list[$];
	int cl_loaded_list[$];

	iei_in_t items_to_send[$];
	iei_out_t awaited_results[$];
	iei_out_t want_beat;

	int err_count = 0;
	int send_gap = 0;
	int ready_gap = 0;
	int hold_left = 0;
	int hold_req = 0;
	bit calm = 1'b0;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		err_count++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	function automatic longint clip(input longint x);
		if (x > longint'(VAL_MAX))
			return longint'(VAL_MAX);
		if (x < longint'(VAL_MIN))
			return longint'(VAL_MIN);
		return x;
	endfunction

	// Resolves a combined node index; returns 0 when it falls outside both stores.
	function automatic bit read_node(input logic [IDX_W-1:0] idx, output longint lvl,
			output longint val);
		logic [IDX_W-1:0] slot;
		lvl = 0;
		val = 0;
		if (idx < point_count) begin
			if (idx >= POINT_DEPTH)
				return 1'b0;
			lvl = pt_level[idx];
			val = pt_data[idx];
			return 1'b1;
		end
		slot = idx - point_count;
		if (slot >= CELL_DEPTH)
			return 1'b0;
		lvl = cl_level[slot];
		val = cl_data[slot];
		return 1'b1;
	endfunction

	// Computes the answer to one input beat and applies any load to the shadow stores.
	function automatic iei_out_t edge_answer(input iei_in_t beat);
		iei_out_t ans;
		longint s0, v0, s1, v1, span, num, frac;
		ans.result_value = '0;
		ans.status = STAT_BAD;
		case (beat.operation)
		OP_LOAD_POINT: begin
			if (beat.first_index < POINT_DEPTH) begin
				pt_level[beat.first_index] = beat.level_in;
				pt_data[beat.first_index] = beat.data_in;
				ans.status = STAT_OK;
			end
		end
		OP_LOAD_CELL: begin
			if (beat.first_index < CELL_DEPTH) begin
				cl_level[beat.first_index] = beat.level_in;
				cl_data[beat.first_index] = beat.data_in;
				ans.status = STAT_OK;
			end
		end
		OP_INTERP: begin
			if (read_node(beat.first_index, s0, v0)) begin
				if (beat.second_index == beat.first_index) begin
					ans.result_value = VALUE_W'(v0);
					ans.status = STAT_SNAP;
				end else if (read_node(beat.second_index, s1, v1)) begin
					span = s1 - s0;
					if (span == 0) begin
						// Flat edge: mean of the two values, rounded down.
						ans.result_value = VALUE_W'((v0 + v1) >>> 1);
						ans.status = STAT_AVG;
					end else begin
						num = (longint'(iso_setting) - s0) * (longint'(1) << Q_SHIFT);
						frac = clip(num / span);
						ans.result_value = VALUE_W'(clip(v0 + ((frac * (v1 - v0)) >>> Q_SHIFT)));
						ans.status = STAT_OK;
					end
				end
			end
		end
		default: ;
		endcase
		return ans;
	endfunction

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Input driver: predicts each accepted beat, then offers the next one after a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_results.push_back(edge_answer(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					in_data <= items_to_send.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each accepted beat and throttles out_ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h stat %0d",
						out_data.result_value, out_data.status));
				end else begin
					want_beat = awaited_results.pop_front();
					if (out_data.result_value !== want_beat.result_value)
						report_mismatch($sformatf("result_value got %h want %h",
							out_data.result_value, want_beat.result_value));
					if (out_data.status !== want_beat.status)
						report_mismatch($sformatf("stat got %0d want %0d",
							out_data.status, want_beat.status));
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				ready_gap = pick_gap();
			end
		end
	end

	// Writes one configuration register and mirrors it in the shadow state.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_ISO_LEVEL:  iso_setting = val;
		REG_NUM_POINTS: point_count = val[IDX_W-1:0];
		default: ;
		endcase
	endtask

	// Sets the node split with random bits above the register width.
	task automatic write_split(input int np);
		logic [VALUE_W-1:0] v;
		v = $urandom;
		v[IDX_W-1:0] = IDX_W'(np);
		write_reg(REG_NUM_POINTS, v);
	endtask

	// Waits until every beat is sent and answered, then lets the pipeline drain.
	task automatic settle();
		@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_item(input iei_in_t beat);
		if (beat.operation == OP_LOAD_POINT && beat.first_index < POINT_DEPTH &&
				!pt_loaded[beat.first_index]) begin
			pt_loaded[beat.first_index] = 1'b1;
			pt_loaded_list.push_back(int'(beat.first_index));
		end
		if (beat.operation == OP_LOAD_CELL && beat.first_index < CELL_DEPTH &&
				!cl_loaded[beat.first_index]) begin
			cl_loaded[beat.first_index] = 1'b1;
			cl_loaded_list.push_back(int'(beat.first_index));
		end
		items_to_send.push_back(beat);
	endtask

	task automatic direct(input op_t op, input int a, input int b,
			input logic [VALUE_W-1:0] lvl, input logic [VALUE_W-1:0] dat);
		iei_in_t beat;
		beat.operation = op;
		beat.first_index = IDX_W'(a);
		beat.second_index = IDX_W'(b);
		beat.level_in = lvl;
		beat.data_in = dat;
		queue_item(beat);
	endtask

	function automatic logic [VALUE_W-1:0] rand_q16();
		case ($urandom_range(0, 9))
		0: return VAL_MAX;
		1: return VAL_MIN;
		2: return '0;
		3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		default: return $urandom;
		endcase
	endfunction

	// Levels repeat often so that flat edges show up.
	function automatic logic [VALUE_W-1:0] rand_level();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return Q_ONE;
		2: return Q_M_ONE;
		default: return rand_q16();
		endcase
	endfunction

	function automatic int load_slot();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return $urandom_range(0, 63);
		if (k < 9)
			return $urandom_range(4032, 4095);
		return $urandom_range(0, IDX_MAX);
	endfunction

	// True when an interpolation may name this index without reading an unloaded entry.
	function automatic bit node_ok(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] slot;
		if (idx < point_count)
			return (idx >= POINT_DEPTH) || pt_loaded[idx];
		slot = idx - point_count;
		return (slot >= CELL_DEPTH) || cl_loaded[slot];
	endfunction

	// Combined index of some loaded entry reachable under the current split.
	function automatic logic [IDX_W-1:0] pick_loaded();
		int t, p;
		for (t = 0; t < 40; t++) begin
			if ($urandom_range(0, 1)) begin
				p = pt_loaded_list[$urandom_range(0, pt_loaded_list.size() - 1)];
				if (p < int'(point_count))
					return IDX_W'(p);
			end else begin
				p = cl_loaded_list[$urandom_range(0, cl_loaded_list.size() - 1)];
				if (int'(point_count) + p <= IDX_MAX)
					return IDX_W'(int'(point_count) + p);
			end
		end
		// Point 0 and cell 0 are both loaded, so index 0 is always safe.
		return '0;
	endfunction

	function automatic logic [IDX_W-1:0] any_index();
		logic [IDX_W-1:0] idx;
		idx = IDX_W'($urandom);
		return node_ok(idx) ? idx : pick_loaded();
	endfunction

	task automatic gen_random_item();
		iei_in_t beat;
		int k;
		beat.first_index = IDX_W'($urandom);
		beat.second_index = IDX_W'($urandom);
		beat.level_in = $urandom;
		beat.data_in = $urandom;
		k = $urandom_range(0, 99);
		if (k < 12) begin
			beat.operation = OP_LOAD_POINT;
			beat.first_index = IDX_W'(load_slot());
			beat.level_in = rand_level();
			beat.data_in = rand_q16();
		end else if (k < 22) begin
			beat.operation = OP_LOAD_CELL;
			beat.first_index = IDX_W'(load_slot());
			beat.level_in = rand_level();
			beat.data_in = rand_q16();
		end else if (k < 26) begin
			beat.operation = OP_UNUSED;
		end else begin
			beat.operation = OP_INTERP;
			beat.first_index = ($urandom_range(0, 9) == 0) ? any_index() : pick_loaded();
			k = $urandom_range(0, 19);
			if (k < 3)
				beat.second_index = beat.first_index;
			else if (k < 5)
				beat.second_index = any_index();
			else
				beat.second_index = pick_loaded();
		end
		queue_item(beat);
	endtask

	task automatic random_phase(input logic [VALUE_W-1:0] iso, input int np, input bit quiet,
			input int hold);
		settle();
		write_reg(REG_ISO_LEVEL, iso);
		write_split(np);
		if ($urandom_range(0, 1))
			write_reg(REG_IDX_W'($urandom_range(REG_UNMAPPED_LO, (1 << REG_IDX_W) - 1)),
				$urandom);
		@(negedge clk);
		calm = quiet;
		hold_req = hold;
		repeat (PHASE_ITEMS) gen_random_item();
	endtask

	// Main sequence: reset, directed edges, then random phases under several settings.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_split(4096);
		write_reg(REG_ISO_LEVEL, '0);
		write_reg(REG_IDX_W'(REG_UNMAPPED_LO), $urandom);
		@(negedge clk);
		direct(OP_LOAD_POINT, 0, $urandom, '0, VAL_MAX);
		direct(OP_LOAD_POINT, 4095, $urandom, VAL_MIN, VAL_MIN);
		direct(OP_LOAD_CELL, 0, $urandom, VAL_MAX, Q_ONE);
		direct(OP_LOAD_CELL, 4095, $urandom, Q_ONE, Q_M_ONE);
		direct(OP_LOAD_POINT, 1, $urandom, Q_ONE, 32'd5);
		direct(OP_LOAD_POINT, 2, $urandom, 32'd1, VAL_MAX);
		direct(OP_LOAD_POINT, 3, $urandom, '0, VAL_MIN);
		// Loads past the end of either store write nothing.
		direct(OP_LOAD_POINT, IDX_MAX, $urandom, $urandom, $urandom);
		direct(OP_LOAD_CELL, 4096, $urandom, $urandom, $urandom);
		direct(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
		direct(OP_INTERP, 0, 0, $urandom, $urandom);
		direct(OP_INTERP, 0, 4095, $urandom, $urandom);
		direct(OP_INTERP, 4095, 4096, $urandom, $urandom);
		direct(OP_INTERP, 4096, 0, $urandom, $urandom);
		direct(OP_INTERP, 1, IDX_MAX, $urandom, $urandom);
		direct(OP_INTERP, IDX_MAX, IDX_MAX, $urandom, $urandom);
		settle();

		// Steepest edges with the iso level at both ends saturate both s and the result.
		write_reg(REG_ISO_LEVEL, VAL_MAX);
		@(negedge clk);
		direct(OP_INTERP, 3, 2, $urandom, $urandom);
		direct(OP_INTERP, 2, 3, $urandom, $urandom);
		settle();

		write_reg(REG_ISO_LEVEL, VAL_MIN);
		write_split(4);
		@(negedge clk);
		direct(OP_INTERP, 3, 2, $urandom, $urandom);
		direct(OP_INTERP, 2, 3, $urandom, $urandom);
		direct(OP_INTERP, 4100, 0, $urandom, $urandom);
		direct(OP_INTERP, 0, 4100, $urandom, $urandom);
		direct(OP_INTERP, 4099, 4, $urandom, $urandom);
		settle();

		// Split above the point depth: indices between the two name missing points.
		write_split(IDX_MAX);
		@(negedge clk);
		direct(OP_INTERP, 4096, 0, $urandom, $urandom);
		direct(OP_INTERP, 0, IDX_MAX, $urandom, $urandom);

		random_phase(rand_q16(), 4096, 1'b0, 0);
		random_phase('0, 0, 1'b0, 0);
		random_phase($urandom, IDX_MAX, 1'b0, 0);
		random_phase(VAL_MAX, $urandom_range(1, IDX_MAX), 1'b0, 0);
		random_phase(VAL_MIN, 100, 1'b1, 0);
		random_phase(rand_q16(), 4096, 1'b0, LONG_HOLD);
		settle();

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iei_pkg.sv
rtl/iei_store.sv
rtl/iei_divider.sv
rtl/iso_edge_interpolator_core.sv
dv/iso_edge_interpolator_core_test.sv
